[rtl/core/rpvg_pkg.sv]
`default_nettype none
package rpvg_pkg;

    localparam int MAX_SIDES     = 63;
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_WIDTH   = 16;

    localparam int SIDE_W  = 6;
    localparam int CTR_W   = 16;
    localparam int RAD_W   = 15;
    localparam int ANG_W   = 16;
    localparam int TRIG_W  = 34;
    localparam int Z_W     = 34;
    localparam int PROD_W  = 50;
    localparam int SUM_W   = 40;
    localparam int QUO_W   = 17;
    localparam int DIVC_W  = 5;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = TRIG_W'(652032874);
    localparam logic [SIDE_W-1:0] MIN_SIDES = SIDE_W'(3);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RUN
    } t_seq_state;

    typedef struct packed {
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic [RAD_W-1:0]        r;
        logic [SIDE_W-1:0]       idx;
        logic                    last;
        logic                    neg;
    } t_meta;

    function automatic logic signed [Z_W-1:0] atan_q32(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = Z_W'(536870912);
            1:       v = Z_W'(316933406);
            2:       v = Z_W'(167458907);
            3:       v = Z_W'(85004756);
            4:       v = Z_W'(42667331);
            5:       v = Z_W'(21354465);
            6:       v = Z_W'(10679838);
            7:       v = Z_W'(5340245);
            8:       v = Z_W'(2670163);
            9:       v = Z_W'(1335087);
            10:      v = Z_W'(667544);
            11:      v = Z_W'(333772);
            12:      v = Z_W'(166886);
            13:      v = Z_W'(83443);
            14:      v = Z_W'(41722);
            15:      v = Z_W'(20861);
            16:      v = Z_W'(10430);
            17:      v = Z_W'(5215);
            18:      v = Z_W'(2608);
            19:      v = Z_W'(1304);
            20:      v = Z_W'(652);
            21:      v = Z_W'(326);
            22:      v = Z_W'(163);
            23:      v = Z_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/core/rpvg_if.sv]
`default_nettype none
interface rpvg_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [rpvg_pkg::SIDE_W-1:0]            side_count;
    logic signed [rpvg_pkg::CTR_W-1:0]      center_x;
    logic signed [rpvg_pkg::CTR_W-1:0]      center_y;
    logic [rpvg_pkg::RAD_W-1:0]             radius_len;
    logic [rpvg_pkg::ANG_W-1:0]             rotation;

    modport source (output valid, side_count, center_x, center_y, radius_len, rotation,
                    input ready);
    modport sink (input valid, side_count, center_x, center_y, radius_len, rotation,
                  output ready);
endinterface

interface rpvg_vtx_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rpvg_pkg::COORD_WIDTH-1:0] vertex_x;
    logic signed [rpvg_pkg::COORD_WIDTH-1:0] vertex_y;
    logic [rpvg_pkg::SIDE_W-1:0]            vertex_index;
    logic                                   last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_index, last_vertex,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_index, last_vertex,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/regular_polygon_vertex_gen_core.sv]
// sequencing: a full turn is first divided by the side count, then each vertex is issued
//   through the quadrant fold, the CORDIC stages, the product register and the output register
// throughput: one vertex per cycle while the output is not stalled; a request of n sides
//   yields n + 1 vertices, and the sequencer accepts the next request only when idle
// reset: synchronous active-low i_rst_n clears sequencer state and all valid bits
`default_nettype none
module regular_polygon_vertex_gen_core (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rpvg_req_if.sink   i_req,
    rpvg_vtx_if.source o_vtx
);
    import rpvg_pkg::*;

    localparam int CS = CORDIC_STAGES;

    t_seq_state r_state, n_state;

    logic [SIDE_W-1:0]       r_n;
    logic signed [CTR_W-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]        r_r;
    logic [ANG_W-1:0]        r_rot;
    logic [QUO_W-1:0]        r_qstep;
    logic [SIDE_W-1:0]       r_rstep;
    logic [DIVC_W-1:0]       r_div_cnt;
    logic [QUO_W-1:0]        r_q;
    logic [SIDE_W-1:0]       r_rem;
    logic [SIDE_W-1:0]       r_k;

    logic                    adv;
    logic                    issue;
    logic [SIDE_W-1:0]       n_sat;
    logic [SIDE_W:0]         div_t;
    logic                    div_bit;
    logic [SIDE_W:0]         rem_sum;
    logic                    rem_wrap;
    logic [ANG_W-1:0]        ang;
    logic signed [ANG_W:0]   ang_d;
    logic signed [ANG_W:0]   ang_f;
    logic                    ang_neg;

    // cordic pipe
    logic                    r_vld [0:CS];
    logic signed [TRIG_W-1:0] r_x [0:CS];
    logic signed [TRIG_W-1:0] r_y [0:CS];
    logic signed [Z_W-1:0]   r_z [0:CS];
    t_meta                   r_m [0:CS];

    logic                    r_pv;
    logic signed [PROD_W-1:0] r_px, r_py;
    t_meta                   r_pm;

    logic                    r_ov;
    logic signed [COORD_WIDTH-1:0] r_ox, r_oy;
    t_meta                   r_om;

    assign adv   = !r_ov || o_vtx.ready;
    assign issue = (r_state == S_RUN) && adv;
    assign i_req.ready = (r_state == S_IDLE);

    assign n_sat = (i_req.side_count > SIDE_W'(MAX_SIDES)) ? SIDE_W'(MAX_SIDES)
                                                           : i_req.side_count;

    // restoring divide of 65536 by n, one quotient bit a cycle
    assign div_bit = (r_div_cnt == '0);
    assign div_t   = {r_rem, div_bit};
    assign rem_sum = {1'b0, r_rem} + {1'b0, r_rstep};
    assign rem_wrap = rem_sum >= {1'b0, r_n};

    assign ang     = r_rot + r_q[ANG_W-1:0];
    assign ang_d   = {ang[ANG_W-1], ang};

    always_comb begin
        ang_f   = ang_d;
        ang_neg = 1'b0;
        if (ang_d > (ANG_W+1)'(16384)) begin
            ang_f   = ang_d - (ANG_W+1)'(32768);
            ang_neg = 1'b1;
        end else if (ang_d < -(ANG_W+1)'(16384)) begin
            ang_f   = ang_d + (ANG_W+1)'(32768);
            ang_neg = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.side_count >= MIN_SIDES) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_div_cnt == DIVC_W'(QUO_W - 1)) n_state = S_RUN;
            end
            S_RUN: begin
                if (issue && r_k == r_n) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n       <= n_sat;
                r_cx      <= i_req.center_x;
                r_cy      <= i_req.center_y;
                r_r       <= i_req.radius_len;
                r_rot     <= i_req.rotation;
                r_rem     <= '0;
                r_qstep   <= '0;
                r_div_cnt <= '0;
            end
            S_DIV: begin
                if (div_t >= {1'b0, r_n}) begin
                    r_qstep <= {r_qstep[QUO_W-2:0], 1'b1};
                end else begin
                    r_qstep <= {r_qstep[QUO_W-2:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == DIVC_W'(QUO_W - 1)) begin
                    r_rstep <= (div_t >= {1'b0, r_n}) ? SIDE_W'(div_t - {1'b0, r_n})
                                                      : div_t[SIDE_W-1:0];
                    r_rem   <= r_n >> 1;
                    r_q     <= '0;
                    r_k     <= '0;
                end else if (div_t >= {1'b0, r_n}) begin
                    r_rem   <= SIDE_W'(div_t - {1'b0, r_n});
                end else begin
                    r_rem   <= div_t[SIDE_W-1:0];
                end
            end
            S_RUN: begin
                if (issue) begin
                    r_k <= r_k + 1'b1;
                    if (rem_wrap) begin
                        r_rem <= SIDE_W'(rem_sum - {1'b0, r_n});
                        r_q   <= r_q + r_qstep + 1'b1;
                    end else begin
                        r_rem <= rem_sum[SIDE_W-1:0];
                        r_q   <= r_q + r_qstep;
                    end
                end
            end
            default: ;
        endcase
    end

    // stage 0: quadrant fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= issue;
        end
        if (adv) begin
            r_x[0]      <= GAIN_Q30;
            r_y[0]      <= '0;
            r_z[0]      <= Z_W'(ang_f) <<< 16;
            r_m[0].cx   <= r_cx;
            r_m[0].cy   <= r_cy;
            r_m[0].r    <= r_r;
            r_m[0].idx  <= r_k;
            r_m[0].last <= (r_k == r_n);
            r_m[0].neg  <= ang_neg;
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (adv) begin
                r_vld[i+1] <= r_vld[i];
            end
            if (adv) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q32(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q32(i);
                end
                r_m[i+1] <= r_m[i];
            end
        end
    end

    logic signed [TRIG_W-1:0] trig_c, trig_s;
    logic signed [RAD_W:0]    rad_s;
    assign trig_c = r_m[CS].neg ? -r_x[CS] : r_x[CS];
    assign trig_s = r_m[CS].neg ? -r_y[CS] : r_y[CS];
    assign rad_s  = {1'b0, r_m[CS].r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (adv) begin
            r_pv <= r_vld[CS];
        end
        if (adv) begin
            r_px <= PROD_W'(rad_s * trig_c);
            r_py <= PROD_W'(rad_s * trig_s);
            r_pm <= r_m[CS];
        end
    end

    localparam logic signed [SUM_W-1:0] C_HI = SUM_W'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
    localparam logic signed [SUM_W-1:0] C_LO = -C_HI - SUM_W'(1);
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(64'sd1 <<< 29);

    function automatic logic signed [COORD_WIDTH-1:0] fin(input logic signed [PROD_W-1:0] p,
                                                          input logic signed [CTR_W-1:0] c);
        logic signed [PROD_W-1:0] sh;
        logic signed [SUM_W-1:0]  v;
        sh = (p + RND) >>> 30;
        v  = SUM_W'(sh) + SUM_W'(c);
        if (v > C_HI) v = C_HI;
        if (v < C_LO) v = C_LO;
        return v[COORD_WIDTH-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_pv;
        end
        if (adv) begin
            r_ox <= fin(r_px, r_pm.cx);
            r_oy <= fin(r_py, r_pm.cy);
            r_om <= r_pm;
        end
    end

    assign o_vtx.valid        = r_ov;
    assign o_vtx.vertex_x     = r_ox;
    assign o_vtx.vertex_y     = r_oy;
    assign o_vtx.vertex_index = r_om.idx;
    assign o_vtx.last_vertex  = r_om.last;

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid && o_vtx.last_vertex |-> o_vtx.vertex_index >= MIN_SIDES)
        else $error("closing item with too small index");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_rem < r_n)
        else $error("offset remainder out of range");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div_cnt < DIVC_W'(QUO_W))
        else $error("divider overran");

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;
    import rpvg_pkg::*;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [SIDE_W-1:0]             idx;
        logic                          last;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    rpvg_req_if req_ch ();
    rpvg_vtx_if vtx_ch ();

    regular_polygon_vertex_gen_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_vtx   (vtx_ch.source)
    );

    t_vertex vertex_queue[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      quiet_tail = 1'b0;
    int      stall_left = 0;

    // predictor state
    logic [ANG_W-1:0]  last_angle = '0;
    logic [ANG_W-1:0]  step_angle = '0;
    logic [6:0]        pending_vertices = '0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(input logic [ANG_W-1:0] ang,
                                    output longint c, output longint s);
        longint d, x, y, z, nx;
        bit     flip;
        d = longint'($signed(ang));
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (d > 16384) begin
            d -= 32768;
            flip = 1'b1;
        end else if (d < -16384) begin
            d += 32768;
            flip = 1'b1;
        end
        z = d * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= longint'(atan_q32(i));
            end else begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += longint'(atan_q32(i));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] place_coord(longint ctr, longint rad,
                                                          longint trig);
        longint hi, lo, v;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        v = floor_shift(rad * trig + (longint'(1) <<< 29), 30) + ctr;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[COORD_WIDTH-1:0];
    endfunction

    task automatic predict_polygon(input logic [SIDE_W-1:0] sides,
                                   input logic signed [CTR_W-1:0] cx,
                                   input logic signed [CTR_W-1:0] cy,
                                   input logic [RAD_W-1:0] rad,
                                   input logic [ANG_W-1:0] rot);
        longint  n, off, c, s;
        t_vertex v;
        logic [ANG_W-1:0] a;
        n = sides;
        if (n < 3) return;
        if (n > MAX_SIDES) n = MAX_SIDES;
        step_angle = ANG_W'(65536 / n);
        pending_vertices = 7'(n + 1);
        for (longint k = 0; k <= n; k++) begin
            off = (k * 65536 + n / 2) / n;
            a = ANG_W'(longint'(rot) + off);
            sin_cos(a, c, s);
            v.x = place_coord(longint'(cx), longint'(rad), c);
            v.y = place_coord(longint'(cy), longint'(rad), s);
            v.idx = SIDE_W'(k);
            v.last = (k == n);
            vertex_queue.push_back(v);
            last_angle = a;
            pending_vertices--;
        end
    endtask

    task automatic idle_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_polygon(input logic [SIDE_W-1:0] sides,
                                input logic signed [CTR_W-1:0] cx,
                                input logic signed [CTR_W-1:0] cy,
                                input logic [RAD_W-1:0] rad,
                                input logic [ANG_W-1:0] rot);
        idle_gap();
        req_ch.valid      <= 1'b1;
        req_ch.side_count <= sides;
        req_ch.center_x   <= cx;
        req_ch.center_y   <= cy;
        req_ch.radius_len <= rad;
        req_ch.rotation   <= rot;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_polygon(sides, cx, cy, rad, rot);
    endtask

    task automatic send_random(input bit wide);
        logic [SIDE_W-1:0] sides;
        sides = wide ? SIDE_W'($urandom) : SIDE_W'($urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0) sides = SIDE_W'($urandom_range(0, 2));
        send_polygon(sides, CTR_W'($urandom), CTR_W'($urandom), RAD_W'($urandom),
                     ANG_W'($urandom));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (quiet_tail) begin
            vtx_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            vtx_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            vtx_ch.ready <= 1'b0;
            stall_left   <= int'($urandom_range(0, 6));
        end else begin
            vtx_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && vtx_ch.valid && vtx_ch.ready) begin
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d idx=%0d last=%0d", $time,
                         vtx_ch.vertex_x, vtx_ch.vertex_y, vtx_ch.vertex_index,
                         vtx_ch.last_vertex);
                error_count++;
            end else begin
                exp_v = vertex_queue.pop_front();
                if (vtx_ch.vertex_x !== exp_v.x || vtx_ch.vertex_y !== exp_v.y ||
                    vtx_ch.vertex_index !== exp_v.idx ||
                    vtx_ch.last_vertex !== exp_v.last) begin
                    $display("%0t: expected x=%0d y=%0d idx=%0d last=%0d, got x=%0d y=%0d idx=%0d last=%0d",
                             $time, exp_v.x, exp_v.y, exp_v.idx, exp_v.last,
                             vtx_ch.vertex_x, vtx_ch.vertex_y, vtx_ch.vertex_index,
                             vtx_ch.last_vertex);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        send_polygon(6'd3, 16'sd0, 16'sd0, 15'h7FFF, 16'h0000);
        send_polygon(6'd0, 16'sd100, 16'sd100, 15'd256, 16'h1234);
        send_polygon(6'd1, 16'sd100, 16'sd100, 15'd256, 16'h1234);
        send_polygon(6'd2, 16'sd100, 16'sd100, 15'd256, 16'h1234);
        send_polygon(6'd63, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 16'hFFFF);
        send_polygon(6'd4, -16'sd32768, -16'sd32768, 15'h7FFF, 16'h4000);
        send_polygon(6'd5, 16'sd1234, -16'sd999, 15'd0, 16'h8000);
        send_polygon(6'd8, 16'sh7FFF, -16'sd32768, 15'h4000, 16'hC000);
        send_polygon(6'd4, 16'sd0, 16'sd0, 15'd1000, 16'h2000);
        send_polygon(6'd7, -16'sd1, 16'sd1, 15'h5555, 16'h5555);
        send_polygon(6'd6, 16'sh5555, -16'sh5556, 15'h2AAA, 16'hAAAA);
        send_polygon(6'd63, 16'sd0, 16'sd0, 15'd1, 16'h0001);
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < 200; i++) send_random($urandom_range(0, 7) == 0);
        wait_drained();
    endtask

    task automatic test_no_idle();
        quiet_tail = 1'b1;
        for (int i = 0; i < 20; i++) send_random(1'b0);
        wait_drained();
    endtask

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.side_count = '0;
        req_ch.center_x   = '0;
        req_ch.center_y   = '0;
        req_ch.radius_len = '0;
        req_ch.rotation   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_no_idle();
        if (error_count == 0 && vertex_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
